// ===== hdl/kcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_pkg
// Shared types and constants of the keyword command decoder: keyword table,
// ASCII codes and the result record.
// ----------------------------------------------------------------------------
package kcd_pkg;

  localparam int KW_COUNT = 4;
  localparam int KW_SLOTS = 8;
  localparam int POS_W    = 4;

  typedef logic [7:0]          char_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;

  // keyword order: LED_ON, LED_OFF, RGB, SERVO
  localparam char_t KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{8'h4C, 8'h45, 8'h44, 8'h5F, 8'h4F, 8'h4E, 8'h00, 8'h00},
    '{8'h4C, 8'h45, 8'h44, 8'h5F, 8'h4F, 8'h46, 8'h46, 8'h00},
    '{8'h52, 8'h47, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h45, 8'h52, 8'h56, 8'h4F, 8'h00, 8'h00, 8'h00}
  };
  localparam pos_t KW_LEN [KW_COUNT] = '{4'd6, 4'd7, 4'd3, 4'd5};

  localparam pos_t  POS_MAX    = 4'(KW_SLOTS);
  localparam char_t CHAR_EQUAL = 8'h3D;
  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0] command_index;
    logic       not_found;
    logic [7:0] argument;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } result_beat_t;

endpackage

// ===== hdl/kcd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_in_if
// Byte channel into the decoder: valid/ready with one message byte per beat.
// ----------------------------------------------------------------------------
interface kcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  logic       is_last;

  modport source (output valid, output rx_char, output is_last, input ready);
  modport sink   (input valid, input rx_char, input is_last, output ready);
endinterface

// ===== hdl/kcd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_out_if
// Result channel of the decoder: valid/ready with one decoded command per beat.
// ----------------------------------------------------------------------------
interface kcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] command_index;
  logic       not_found;
  logic [7:0] argument;

  modport source (output valid, output command_index, output not_found,
                  output argument, input ready);
  modport sink   (input valid, input command_index, input not_found,
                  input argument, output ready);
endinterface

// ===== hdl/keyword_command_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_command_decoder
// Decodes "NAME=value" text messages into a command index and an 8-bit value.
//
// in_bus carries one message byte per beat, with is_last on the final byte.
// The name is matched against LED_ON, LED_OFF, RGB and SERVO as a prefix;
// the first match in that order wins. Decimal digits after the first '='
// build the value modulo 256; other value bytes are ignored. Bytes after the
// first MAX_MESSAGE_LEN of a message are ignored, but is_last still ends it.
// out_bus carries one beat per message: command_index, not_found, argument.
// Throughput is one byte per cycle; the prefix compare and value update are
// a single combinational pass on the message state registers.
// out_bus shows the result of the last byte from the registered output stage.
// When out_bus stalls, one more result fits in a skid register; in_bus.ready
// drops only while both result registers are full.
// Synchronous reset clears the message state and discards pending results.
// ----------------------------------------------------------------------------
module keyword_command_decoder #(
  parameter int MAX_MESSAGE_LEN = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  kcd_in_if.sink    in_bus,
  kcd_out_if.source out_bus
);

  kcd_pkg::result_beat_t res;
  kcd_pkg::result_t      out_data;
  logic                  room;
  logic                  take;

  assign in_bus.ready = room;
  assign take         = in_bus.valid && room;

  kcd_parse #(
    .MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_char (in_bus.rx_char),
    .is_last (in_bus.is_last),
    .res     (res)
  );

  kcd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_data  (out_data)
  );

  assign out_bus.command_index = out_data.command_index;
  assign out_bus.not_found     = out_data.not_found;
  assign out_bus.argument      = out_data.argument;

endmodule

// ===== hdl/kcd_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_parse
// Message state and per-byte update: keyword prefix match, value accumulate
// and the result of the final byte.
// ----------------------------------------------------------------------------
module kcd_parse #(
  parameter int MAX_MESSAGE_LEN = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  kcd_pkg::char_t         rx_char,
  input  logic                   is_last,
  output kcd_pkg::result_beat_t  res
);

  localparam int CNT_W = $clog2(MAX_MESSAGE_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE_LEN);

  logic               in_value_part_r, in_value_part_nxt;
  kcd_pkg::pos_t      name_pos_r, name_pos_nxt;
  kcd_pkg::kw_mask_t  match_mask_r, match_mask_nxt;
  logic [7:0]         value_acc_r, value_acc_nxt;
  logic [CNT_W-1:0]   byte_cnt_r, byte_cnt_nxt;

  kcd_pkg::kw_mask_t  upd_mask;
  kcd_pkg::pos_t      upd_pos;
  logic               upd_value_part;
  logic [7:0]         upd_acc;
  logic [CNT_W-1:0]   upd_cnt;
  logic               found;

  always_comb begin
    logic [7:0] digit;
    upd_mask       = match_mask_r;
    upd_pos        = name_pos_r;
    upd_value_part = in_value_part_r;
    upd_acc        = value_acc_r;
    upd_cnt        = byte_cnt_r;
    digit          = rx_char - kcd_pkg::CHAR_ZERO;
    if (byte_cnt_r < CNT_MAX) begin
      upd_cnt = byte_cnt_r + 1'b1;
      if (!in_value_part_r) begin
        if (rx_char == kcd_pkg::CHAR_EQUAL) begin
          upd_value_part = 1'b1;
        end else if (name_pos_r >= kcd_pkg::POS_MAX) begin
          upd_mask = '0;
        end else begin
          for (int k = 0; k < kcd_pkg::KW_COUNT; k++) begin
            if (name_pos_r >= kcd_pkg::KW_LEN[k] ||
                kcd_pkg::KW_TEXT[k][name_pos_r[2:0]] != rx_char) begin
              upd_mask[k] = 1'b0;
            end
          end
          upd_pos = name_pos_r + 1'b1;
        end
      end else if (rx_char >= kcd_pkg::CHAR_ZERO && rx_char <= kcd_pkg::CHAR_NINE) begin
        upd_acc = (value_acc_r << 3) + (value_acc_r << 1) + digit;
      end
    end
  end

  // first matching keyword in table order wins
  always_comb begin
    found = upd_value_part && (upd_pos != '0) && (upd_mask != '0);
    res.push = take && is_last;
    res.data.not_found = !found;
    res.data.argument  = upd_value_part ? upd_acc : 8'd0;
    priority if (!found)     res.data.command_index = 2'd0;
    else if (upd_mask[0])    res.data.command_index = 2'd0;
    else if (upd_mask[1])    res.data.command_index = 2'd1;
    else if (upd_mask[2])    res.data.command_index = 2'd2;
    else                     res.data.command_index = 2'd3;
  end

  always_comb begin
    in_value_part_nxt = in_value_part_r;
    name_pos_nxt      = name_pos_r;
    match_mask_nxt    = match_mask_r;
    value_acc_nxt     = value_acc_r;
    byte_cnt_nxt      = byte_cnt_r;
    if (take) begin
      if (is_last) begin
        in_value_part_nxt = 1'b0;
        name_pos_nxt      = '0;
        match_mask_nxt    = '1;
        value_acc_nxt     = '0;
        byte_cnt_nxt      = '0;
      end else begin
        in_value_part_nxt = upd_value_part;
        name_pos_nxt      = upd_pos;
        match_mask_nxt    = upd_mask;
        value_acc_nxt     = upd_acc;
        byte_cnt_nxt      = upd_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_part_r <= 1'b0;
      name_pos_r      <= '0;
      match_mask_r    <= '1;
      value_acc_r     <= '0;
      byte_cnt_r      <= '0;
    end else begin
      in_value_part_r <= in_value_part_nxt;
      name_pos_r      <= name_pos_nxt;
      match_mask_r    <= match_mask_nxt;
      value_acc_r     <= value_acc_nxt;
      byte_cnt_r      <= byte_cnt_nxt;
    end
  end

endmodule

// ===== hdl/kcd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_out_buf
// Output register with a skid stage, so the byte side keeps moving while a
// result waits for the receiver.
// ----------------------------------------------------------------------------
module kcd_out_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  kcd_pkg::result_beat_t res,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output kcd_pkg::result_t      out_data
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  kcd_pkg::result_t  main_r, main_nxt;
  kcd_pkg::result_t  skid_r, skid_nxt;
  logic              pop;

  assign room      = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign pop       = main_valid_r && out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = res.push;
        main_nxt       = res.data;
      end
    end else if (res.push) begin
      if (!main_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = res.data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== hdl/kcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcd_checker
// Port-level checks of the keyword command decoder, bound to the top level.
// ----------------------------------------------------------------------------
module kcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_is_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_command_index,
  input logic       out_not_found,
  input logic [7:0] out_argument
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_index) &&
      $stable(out_not_found) && $stable(out_argument))
    else $error("result beat changed while stalled");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_last |=> out_valid)
    else $error("no result after last byte");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_is_last))
    else $error("result without a last byte");

  a_not_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_found |-> out_command_index == 2'd0)
    else $error("not found with nonzero index");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("byte side stalled with no result pending");

endmodule

bind keyword_command_decoder kcd_checker u_kcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_bus.valid),
  .in_ready          (in_bus.ready),
  .in_is_last        (in_bus.is_last),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .out_command_index (out_bus.command_index),
  .out_not_found     (out_bus.not_found),
  .out_argument      (out_bus.argument)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword command decoder. Messages of the form
// NAME=value are fed one byte per beat: a short directed set first, then
// random messages, mostly well-formed keyword prefixes with random values,
// mixed with long names, missing '=', raw byte noise and overlong messages.
// A scoreboard decodes each accepted byte alongside the block and compares
// every result beat field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MSG_LIMIT   = 32;
  localparam int NAME_SLOTS  = 8;
  localparam int BYTE_TARGET = 2000;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {CMD_LED_ON, CMD_LED_OFF, CMD_RGB, CMD_SERVO} command_e;

  class decode_scoreboard;
    string             keywords[4];
    kcd_pkg::result_t  expected_q[$];
    bit                value_part;
    int                name_pos;
    logic [3:0]        match;
    logic [7:0]        value_acc;
    int                taken;
    int                errors;
    int                checked;
    int                misses;
    int                hits[4];

    function new();
      keywords = '{"LED_ON", "LED_OFF", "RGB", "SERVO"};
      errors = 0;
      checked = 0;
      misses = 0;
      hits = '{0, 0, 0, 0};
      clear_message();
    endfunction

    function void clear_message();
      value_part = 1'b0;
      name_pos = 0;
      match = 4'hF;
      value_acc = 8'd0;
      taken = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // decode one accepted beat, queue the result on the last byte
    function void note_input(kcd_pkg::char_t c, bit last);
      kcd_pkg::result_t exp;
      if (taken < MSG_LIMIT) begin
        taken++;
        if (!value_part) begin
          if (c == kcd_pkg::CHAR_EQUAL) begin
            value_part = 1'b1;
          end else if (name_pos >= NAME_SLOTS) begin
            match = 4'h0;
          end else begin
            for (int k = 0; k < 4; k++) begin
              if (name_pos >= keywords[k].len() ||
                  kcd_pkg::char_t'(keywords[k][name_pos]) != c) begin
                match[k] = 1'b0;
              end
            end
            name_pos++;
          end
        end else if (c >= kcd_pkg::CHAR_ZERO && c <= kcd_pkg::CHAR_NINE) begin
          value_acc = value_acc * 8'd10 + (c - kcd_pkg::CHAR_ZERO);
        end
      end
      if (last) begin
        exp.command_index = CMD_LED_ON;
        exp.not_found = 1'b1;
        exp.argument = value_part ? value_acc : 8'd0;
        if (value_part && name_pos != 0) begin
          // lowest keyword index wins
          for (int k = 3; k >= 0; k--) begin
            if (match[k]) begin
              exp.command_index = 2'(k);
              exp.not_found = 1'b0;
            end
          end
        end
        expected_q.push_back(exp);
        clear_message();
      end
    endfunction

    task report(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(kcd_pkg::result_t got);
      kcd_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        report("result beat with no message pending", got, -1);
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.not_found) misses++;
      else hits[exp.command_index]++;
      if (got.command_index !== exp.command_index)
        report("command_index", got.command_index, exp.command_index);
      if (got.not_found !== exp.not_found)
        report("not_found", got.not_found, exp.not_found);
      if (got.argument !== exp.argument)
        report("argument", got.argument, exp.argument);
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  bit   in_quiet;
  bit   out_quiet;
  int   bytes_taken;
  int   msgs_sent;
  kcd_pkg::char_t msg[$];
  string kw_names[4] = '{"LED_ON", "LED_OFF", "RGB", "SERVO"};
  decode_scoreboard sb;

  kcd_in_if  in_bus ();
  kcd_out_if out_bus ();

  keyword_command_decoder #(.MAX_MESSAGE_LEN(MSG_LIMIT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, sb.pending());
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) msg.push_back(kcd_pkg::char_t'(s[i]));
  endfunction

  function automatic kcd_pkg::char_t random_digit();
    return kcd_pkg::CHAR_ZERO + kcd_pkg::char_t'($urandom_range(0, 9));
  endfunction

  function automatic kcd_pkg::char_t random_upper();
    return kcd_pkg::char_t'($urandom_range(65, 90));
  endfunction

  function automatic void build_random_message();
    int    kind;
    int    plen;
    int    n;
    string kw;
    kind = $urandom_range(0, 15);
    kw = kw_names[$urandom_range(0, 3)];
    if (kind < 10) begin
      // keyword prefix, sometimes damaged or stretched, then a value
      plen = ($urandom_range(0, 1) == 1) ? kw.len() : $urandom_range(1, kw.len());
      for (int i = 0; i < plen; i++) msg.push_back(kcd_pkg::char_t'(kw[i]));
      if ($urandom_range(0, 5) == 0)
        msg[$urandom_range(0, plen - 1)] = kcd_pkg::char_t'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 4)) msg.push_back(random_upper());
      msg.push_back(kcd_pkg::CHAR_EQUAL);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 7) == 0) msg.push_back(kcd_pkg::char_t'($urandom_range(0, 255)));
        else msg.push_back(random_digit());
      end
    end else if (kind < 12) begin
      // name only, no separator
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) begin
        if (i < kw.len() && $urandom_range(0, 1) == 1) msg.push_back(kcd_pkg::char_t'(kw[i]));
        else msg.push_back(random_upper());
      end
    end else if (kind < 14) begin
      repeat ($urandom_range(1, 12)) msg.push_back(kcd_pkg::char_t'($urandom_range(0, 255)));
    end else if (kind == 14) begin
      n = $urandom_range(MSG_LIMIT + 1, MSG_LIMIT + 12);
      if ($urandom_range(0, 1) == 1) begin
        // separator lands past the length cap
        while (msg.size() < n) msg.push_back(random_upper());
        msg.push_back(kcd_pkg::CHAR_EQUAL);
        msg.push_back(random_digit());
      end else begin
        for (int i = 0; i < kw.len(); i++) msg.push_back(kcd_pkg::char_t'(kw[i]));
        msg.push_back(kcd_pkg::CHAR_EQUAL);
        while (msg.size() < n) begin
          if ($urandom_range(0, 3) == 0) msg.push_back(kcd_pkg::char_t'($urandom_range(0, 255)));
          else msg.push_back(random_digit());
        end
      end
    end else begin
      msg.push_back(kcd_pkg::CHAR_EQUAL);
      repeat ($urandom_range(0, 4)) msg.push_back(random_digit());
    end
  endfunction

  task automatic send_byte(kcd_pkg::char_t c, bit last);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_char <= c;
    in_bus.is_last <= last;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_input(c, last);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    bytes_taken += (msg.size() < MSG_LIMIT) ? msg.size() : MSG_LIMIT;
    msgs_sent++;
    msg.delete();
    if ($urandom_range(0, 9) == 0) in_quiet = !in_quiet;
  endtask

  // result side: random stall before each beat
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      sb.check_result('{command_index: out_bus.command_index,
                        not_found:     out_bus.not_found,
                        argument:      out_bus.argument});
      if ($urandom_range(0, 9) == 0) out_quiet = !out_quiet;
    end
  end

  initial begin
    sb = new();
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    bytes_taken = 0;
    msgs_sent = 0;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_char <= 8'h00;
    in_bus.is_last <= 1'b0;
    out_bus.ready  <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // longest keyword, largest value
    add_text("LED_OFF=255");
    send_msg();
    // empty name
    add_text("=");
    send_msg();
    // no separator
    add_text("RGB");
    send_msg();
    // second '=' and a zero byte in the value are skipped
    add_text("R=9=");
    msg.push_back(8'h00);
    send_msg();
    // top byte value as a name
    msg.push_back(8'hFF);
    add_text("=1");
    send_msg();
    msg.push_back(8'h00);
    send_msg();

    while (bytes_taken < BYTE_TARGET) begin
      build_random_message();
      send_msg();
    end
    in_bus.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d messages (%0d counted bytes), checked %0d results", msgs_sent,
             bytes_taken, sb.checked);
    $display("LED_ON %0d, LED_OFF %0d, RGB %0d, SERVO %0d, not found %0d, mismatches %0d",
             sb.hits[CMD_LED_ON], sb.hits[CMD_LED_OFF], sb.hits[CMD_RGB],
             sb.hits[CMD_SERVO], sb.misses, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
